FILE: hdl/color_temperature_to_rgb_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the color temperature converter
// ---------------------------------------------------------------------------
`ifndef COLOR_TEMPERATURE_TO_RGB_TOP_MACROS_SVH
`define COLOR_TEMPERATURE_TO_RGB_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CTRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CTRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ctrt_pkg.sv
// ---------------------------------------------------------------------------
// ctrt_pkg
// Types and fixed constants of the color temperature to RGB converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctrt_pkg;

  localparam logic [13:0] T_MIN = 14'd1000;
  localparam logic [13:0] T_MAX = 14'd15000;

  // Polynomial coefficients of the locus approximation, scaled by 10^16
  localparam logic [63:0] C_NU0 = 64'd8601177570000000;
  localparam logic [63:0] C_NU1 = 64'd1541182540000;
  localparam logic [63:0] C_NU2 = 64'd1286412120;
  localparam logic [63:0] C_DU0 = 64'd10000000000000000;
  localparam logic [63:0] C_DU1 = 64'd8424202350000;
  localparam logic [63:0] C_DU2 = 64'd7081451630;
  localparam logic [63:0] C_NV0 = 64'd3173987260000000;
  localparam logic [63:0] C_NV1 = 64'd422806245000;
  localparam logic [63:0] C_NV2 = 64'd420481691;
  localparam logic [63:0] C_DV0 = 64'd10000000000000000;
  localparam logic [63:0] C_DV1 = 64'd289741816000;
  localparam logic [63:0] C_DV2 = 64'd1614560530;

  // XYZ to linear sRGB matrix, scaled by 10^7
  localparam logic signed [25:0] M_RX = 26'sd32404542;
  localparam logic signed [25:0] M_RY = -26'sd15371385;
  localparam logic signed [25:0] M_RZ = -26'sd4985314;
  localparam logic signed [25:0] M_GX = -26'sd9692660;
  localparam logic signed [25:0] M_GY = 26'sd18760108;
  localparam logic signed [25:0] M_GZ = 26'sd415560;
  localparam logic signed [25:0] M_BX = 26'sd556434;
  localparam logic signed [25:0] M_BY = -26'sd2040259;
  localparam logic signed [25:0] M_BZ = 26'sd10572250;

  // Y is 1.0 in Q32, so its column reduces to shifted constants
  localparam logic signed [63:0] Y_R = 64'(M_RY) <<< 32;
  localparam logic signed [63:0] Y_G = 64'(M_GY) <<< 32;
  localparam logic signed [63:0] Y_B = 64'(M_BY) <<< 32;

  // 4.0 in Q32
  localparam logic signed [36:0] FOUR_Q32 = 37'sd17179869184;

  typedef struct packed {
    logic [13:0] t;
    logic [27:0] t2;
  } item_t;

endpackage

FILE: hdl/ctrt_front.sv
// ---------------------------------------------------------------------------
// ctrt_front
// Accepts temperature requests, saturates them to range and squares them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctrt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [13:0]     temp_kelvin_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output ctrt_pkg::item_t item_o,
  output logic            vld_o,
  input  logic            rdy_i
);
  import ctrt_pkg::*;

  logic        en;
  logic        vld_q;
  item_t       item_q;
  item_t       item_d;
  logic [13:0] t_sat;

  assign en         = !vld_q || rdy_i;
  assign in_ready_o = en;

  always_comb begin
    priority if (temp_kelvin_i < T_MIN) begin
      t_sat = T_MIN;
    end else if (temp_kelvin_i > T_MAX) begin
      t_sat = T_MAX;
    end else begin
      t_sat = temp_kelvin_i;
    end
    item_d.t  = t_sat;
    item_d.t2 = 28'(t_sat) * 28'(t_sat);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

FILE: hdl/ctrt_fifo.sv
// ---------------------------------------------------------------------------
// ctrt_fifo
// Two-entry request queue between the front and the back pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "color_temperature_to_rgb_top_macros.svh"

module ctrt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_vld_i,
  output logic            push_rdy_o,
  input  ctrt_pkg::item_t push_item_i,
  output logic            pop_vld_o,
  input  logic            pop_rdy_i,
  output ctrt_pkg::item_t pop_item_o
);
  import ctrt_pkg::*;

  item_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;

  assign push_rdy_o = (cnt_q != 2'd2);
  assign pop_vld_o  = (cnt_q != 2'd0);
  assign push       = push_vld_i && push_rdy_o;
  assign pop        = pop_vld_o && pop_rdy_i;
  assign pop_item_o = mem_q[rd_q];

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  `CTRT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q != 2'd3, "queue count out of range")
  `CTRT_ASSERT_NXT(a_cnt_inc, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "push lost")
  `CTRT_ASSERT_NXT(a_cnt_dec, pop && !push, cnt_q == $past(cnt_q) - 2'd1, "pop lost")

endmodule

FILE: hdl/ctrt_div.sv
// ---------------------------------------------------------------------------
// ctrt_div
// Pipelined restoring divider, one quotient bit per stage, rounded result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctrt_div #(
  parameter int NW = 61,
  parameter int DW = 61,
  parameter int IB = 0,
  parameter int FB = 32,
  parameter int TW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [NW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  input  logic [TW-1:0]    tag_i,
  output logic             vld_o,
  output logic [IB+FB:0]   quo_o,
  output logic [TW-1:0]    tag_o
);
  // Quotient needs IB integer bits, FB fraction bits and one rounding bit
  localparam int QW = IB + FB + 1;
  localparam int AW = NW + FB + 1;

  logic [AW-1:0] a_w;
  logic [DW-1:0] rem_init;

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] rem_p [QW];
  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] lo_p  [QW];
  logic [QW-1:0] lo_d  [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] quo_p [QW];
  logic [QW-1:0] quo_d [QW];
  logic [DW-1:0] den_q [QW];
  logic [DW-1:0] den_p [QW];
  logic [TW-1:0] tag_q [QW];
  logic [TW-1:0] tag_p [QW];
  logic [QW-1:0] vld_q;
  logic [QW:0]   rnd;

  // Upper part of the scaled dividend is below the divisor by range
  assign a_w      = AW'(num_i) << (FB + 1);
  assign rem_init = DW'(a_w >> QW);

  always_comb begin : stage_comb
    logic [DW:0] r2;
    logic        ge;
    rem_p[0] = rem_init;
    lo_p[0]  = a_w[QW-1:0];
    quo_p[0] = '0;
    den_p[0] = den_i;
    tag_p[0] = tag_i;
    for (int i = 1; i < QW; i++) begin
      rem_p[i] = rem_q[i-1];
      lo_p[i]  = lo_q[i-1];
      quo_p[i] = quo_q[i-1];
      den_p[i] = den_q[i-1];
      tag_p[i] = tag_q[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      r2       = {rem_p[i], lo_p[i][QW-1]};
      ge       = (r2 >= {1'b0, den_p[i]});
      rem_d[i] = ge ? DW'(r2 - {1'b0, den_p[i]}) : DW'(r2);
      quo_d[i] = {quo_p[i][QW-2:0], ge};
      lo_d[i]  = lo_p[i] << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      lo_q  <= lo_d;
      quo_q <= quo_d;
      den_q <= den_p;
      tag_q <= tag_p;
    end
  end

  // Round to nearest, ties up: drop the extra bit after adding one
  assign rnd   = {1'b0, quo_q[QW-1]} + (QW+1)'(1);
  assign quo_o = rnd[QW:1];
  assign vld_o = vld_q[QW-1];
  assign tag_o = tag_q[QW-1];

endmodule

FILE: hdl/ctrt_back.sv
// ---------------------------------------------------------------------------
// ctrt_back
// Locus polynomials, u/v and XYZ divisions, matrix, normalize and clamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctrt_back #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  output logic            rdy_o,
  input  ctrt_pkg::item_t item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [15:0]     red_o,
  output logic [15:0]     green_o,
  output logic [15:0]     blue_o
);
  import ctrt_pkg::*;

  localparam int QO = OUT_FRAC_BITS + 2;
  localparam int OW = (QO > 17) ? QO : 17;
  localparam logic [OW-1:0] ONE = OW'(1) << OUT_FRAC_BITS;
  localparam logic [OW-1:0] SAT = OW'(16'hFFFF);

  logic en;
  logic out_vld_q;

  // stage 0: polynomial terms
  logic        p0_vld_q;
  logic [63:0] nu1_q, nu2_q, du1_q, du2_q, nv1_q, nv2_q, dv1_q, dv2_q;
  // stage 1: polynomials
  logic        p1_vld_q;
  logic [63:0] nu_q, du_q, nv_q, dv_q;
  // u and v in Q32
  logic        uv_vld;
  logic [32:0] u_w, v_w;
  // stage 2: operands of X and Z
  logic               p2_vld_q;
  logic [34:0]        xn_q;
  logic [33:0]        dxz_q;
  logic [35:0]        zmag_q;
  logic               zneg_q;
  logic signed [36:0] zn_w;
  // X and Z in Q32
  logic        xz_vld;
  logic [35:0] x_w, zm_w;
  logic        zneg_w;
  // stage 3: signed X and Z
  logic               p3_vld_q;
  logic signed [36:0] xs_q, zs_q;
  // stage 4: matrix products
  logic               p4_vld_q;
  logic signed [63:0] rx_q, rz_q, gx_q, gz_q, bx_q, bz_q;
  // stage 5: channels
  logic               p5_vld_q;
  logic signed [63:0] ch_q [3];
  // stage 6: maximum and divider operands
  logic               p6_vld_q;
  logic signed [63:0] m_w;
  logic [62:0]        num_q [3];
  logic [62:0]        den_q;
  logic [2:0]         zero_q;
  // normalized channels
  logic [2:0]         od_vld;
  logic [QO-1:0]      oq_w [3];
  logic [2:0]         otag_w;
  logic [15:0]        out_d [3];
  logic [15:0]        out_q [3];

  assign en    = !out_vld_q || out_ready_i;
  assign rdy_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q  <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      p4_vld_q  <= 1'b0;
      p5_vld_q  <= 1'b0;
      p6_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      p0_vld_q  <= vld_i;
      p1_vld_q  <= p0_vld_q;
      p2_vld_q  <= uv_vld;
      p3_vld_q  <= xz_vld;
      p4_vld_q  <= p3_vld_q;
      p5_vld_q  <= p4_vld_q;
      p6_vld_q  <= p5_vld_q;
      out_vld_q <= od_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nu1_q <= C_NU1 * 64'(item_i.t);
      nu2_q <= C_NU2 * 64'(item_i.t2);
      du1_q <= C_DU1 * 64'(item_i.t);
      du2_q <= C_DU2 * 64'(item_i.t2);
      nv1_q <= C_NV1 * 64'(item_i.t);
      nv2_q <= C_NV2 * 64'(item_i.t2);
      dv1_q <= C_DV1 * 64'(item_i.t);
      dv2_q <= C_DV2 * 64'(item_i.t2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nu_q <= C_NU0 + nu1_q + nu2_q;
      du_q <= C_DU0 + du1_q + du2_q;
      nv_q <= C_NV0 + nv1_q + nv2_q;
      dv_q <= C_DV0 - dv1_q + dv2_q;
    end
  end

  ctrt_div #(.NW(61), .DW(61), .IB(0), .FB(32), .TW(1)) u_div_u (
    .clk_i (clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(p1_vld_q),
    .num_i (nu_q[60:0]), .den_i(du_q[60:0]), .tag_i(1'b0),
    .vld_o (uv_vld), .quo_o(u_w), .tag_o()
  );

  ctrt_div #(.NW(61), .DW(61), .IB(0), .FB(32), .TW(1)) u_div_v (
    .clk_i (clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(p1_vld_q),
    .num_i (nv_q[60:0]), .den_i(dv_q[60:0]), .tag_i(1'b0),
    .vld_o (), .quo_o(v_w), .tag_o()
  );

  assign zn_w = FOUR_Q32 - $signed(37'(u_w)) - $signed(37'(v_w) * 37'd10);

  always_ff @(posedge clk_i) begin
    if (en) begin
      xn_q   <= 35'({u_w, 1'b0}) + 35'(u_w);
      dxz_q  <= {v_w, 1'b0};
      zneg_q <= zn_w[36];
      zmag_q <= zn_w[36] ? 36'(-zn_w) : 36'(zn_w);
    end
  end

  ctrt_div #(.NW(35), .DW(34), .IB(3), .FB(32), .TW(1)) u_div_x (
    .clk_i (clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(p2_vld_q),
    .num_i (xn_q), .den_i(dxz_q), .tag_i(zneg_q),
    .vld_o (xz_vld), .quo_o(x_w), .tag_o()
  );

  ctrt_div #(.NW(36), .DW(34), .IB(3), .FB(32), .TW(1)) u_div_z (
    .clk_i (clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(p2_vld_q),
    .num_i (zmag_q), .den_i(dxz_q), .tag_i(zneg_q),
    .vld_o (), .quo_o(zm_w), .tag_o(zneg_w)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      xs_q <= $signed({1'b0, x_w});
      zs_q <= zneg_w ? -$signed({1'b0, zm_w}) : $signed({1'b0, zm_w});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q <= 64'(M_RX) * 64'(xs_q);
      rz_q <= 64'(M_RZ) * 64'(zs_q);
      gx_q <= 64'(M_GX) * 64'(xs_q);
      gz_q <= 64'(M_GZ) * 64'(zs_q);
      bx_q <= 64'(M_BX) * 64'(xs_q);
      bz_q <= 64'(M_BZ) * 64'(zs_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ch_q[0] <= rx_q + Y_R + rz_q;
      ch_q[1] <= gx_q + Y_G + gz_q;
      ch_q[2] <= bx_q + Y_B + bz_q;
    end
  end

  always_comb begin
    m_w = ch_q[0];
    if (ch_q[1] > m_w) begin
      m_w = ch_q[1];
    end
    if (ch_q[2] > m_w) begin
      m_w = ch_q[2];
    end
  end

  // Force channels to zero when they or the maximum are not positive
  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q <= (m_w > 64'sd0) ? m_w[62:0] : 63'd1;
      for (int c = 0; c < 3; c++) begin
        zero_q[c] <= (ch_q[c] <= 64'sd0) || (m_w <= 64'sd0);
        num_q[c]  <= (ch_q[c] > 64'sd0) ? ch_q[c][62:0] : 63'd0;
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_norm
    ctrt_div #(.NW(63), .DW(63), .IB(1), .FB(OUT_FRAC_BITS), .TW(1)) u_div_o (
      .clk_i (clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(p6_vld_q),
      .num_i (num_q[c]), .den_i(den_q), .tag_i(zero_q[c]),
      .vld_o (od_vld[c]), .quo_o(oq_w[c]), .tag_o(otag_w[c])
    );
  end

  always_comb begin : clamp_comb
    logic [OW-1:0] qv;
    logic [OW-1:0] lim;
    for (int c = 0; c < 3; c++) begin
      qv = OW'(oq_w[c]);
      priority if (otag_w[c]) begin
        lim = '0;
      end else if (qv > ONE) begin
        lim = ONE;
      end else begin
        lim = qv;
      end
      out_d[c] = (lim > SAT) ? 16'hFFFF : lim[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_o       = out_q[0];
  assign green_o     = out_q[1];
  assign blue_o      = out_q[2];

endmodule

FILE: hdl/color_temperature_to_rgb_top.sv
// ---------------------------------------------------------------------------
// color_temperature_to_rgb_top
// Color temperature in kelvin to normalized linear sRGB.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  request   in         in_valid_i / in_ready_o   temp_kelvin_i[13:0]
//  result    out        out_valid_o / out_ready_i red_o, green_o, blue_o [15:0]
//
//  One request per cycle is accepted while the result side keeps up.
//  The result path runs through the three chained bit-per-stage dividers
//  (u/v, X/Z, normalize) plus the surrounding stages. The front stage and
//  the two-entry queue keep taking requests until the queue is full while
//  the back pipeline holds on a stalled result; the back stalls as one piece.
//  Reset clears all valid flags and queue pointers; data registers keep
//  whatever they hold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module color_temperature_to_rgb_top #(
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [13:0] temp_kelvin_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] red_o,
  output logic [15:0] green_o,
  output logic [15:0] blue_o
);
  import ctrt_pkg::*;

  item_t front_item, queue_item;
  logic  front_vld, front_rdy;
  logic  queue_vld, queue_rdy;

  ctrt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .temp_kelvin_i(temp_kelvin_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_o       (front_item),
    .vld_o        (front_vld),
    .rdy_i        (front_rdy)
  );

  ctrt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_vld_i (front_vld),
    .push_rdy_o (front_rdy),
    .push_item_i(front_item),
    .pop_vld_o  (queue_vld),
    .pop_rdy_i  (queue_rdy),
    .pop_item_o (queue_item)
  );

  ctrt_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (queue_vld),
    .rdy_o      (queue_rdy),
    .item_i     (queue_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o)
  );

endmodule

FILE: tb/tb_color_temperature_to_rgb_top.sv
// ---------------------------------------------------------------------------
// tb_color_temperature_to_rgb_top
// Checks the color temperature converter against a fixed-point predictor.
// Requests go in over valid/ready with random gaps, and results are taken
// with random stalls. Each result is compared with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_color_temperature_to_rgb_top;

  localparam int FRAC_BITS   = 15;
  localparam int LATENCY     = 81 + FRAC_BITS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [13:0] temp_kelvin_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] red_o, green_o, blue_o;

  rgb_t        rgb_expected_q[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          quiet_phase = 1'b0;

  color_temperature_to_rgb_top #(.OUT_FRAC_BITS(FRAC_BITS)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .temp_kelvin_i,
    .out_valid_o, .out_ready_i, .red_o, .green_o, .blue_o
  );

  always #5 clk_i = ~clk_i;

  // Rounded a * 2^f / b, ties up; zero divisor gives zero
  function automatic logic [63:0] round_div(logic [63:0] a, logic [63:0] b, int f);
    logic [63:0] q, r;
    if (b == 0) return 0;
    q = a / b;
    r = a % b;
    for (int i = 0; i < f + 1; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q[0] = 1'b1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic longint signed_round_div(longint a, longint b, int f);
    if (b <= 0) return 0;
    if (a < 0) return -longint'(round_div(64'(-a), 64'(b), f));
    return longint'(round_div(64'(a), 64'(b), f));
  endfunction

  function automatic logic [15:0] channel_ratio(longint c, longint m);
    logic [63:0] q;
    if (c <= 0) return 0;
    q = round_div(64'(c), 64'(m), FRAC_BITS);
    if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
    if (q > 64'hFFFF) q = 64'hFFFF;
    return q[15:0];
  endfunction

  function automatic rgb_t kelvin_to_rgb(logic [13:0] raw);
    longint t, t2, nu, du, nv, dv, u, v, x, y, z, r, g, b, m;
    rgb_t res;
    res = '{0, 0, 0};
    t = raw < ctrt_pkg::T_MIN ? ctrt_pkg::T_MIN :
        raw > ctrt_pkg::T_MAX ? ctrt_pkg::T_MAX : raw;
    t2 = t * t;
    nu = 64'd8601177570000000 + 64'd1541182540000 * t + 64'd1286412120 * t2;
    du = 64'd10000000000000000 + 64'd8424202350000 * t + 64'd7081451630 * t2;
    nv = 64'd3173987260000000 + 64'd422806245000 * t + 64'd420481691 * t2;
    dv = 64'd10000000000000000 - 64'd289741816000 * t + 64'd1614560530 * t2;
    u = signed_round_div(nu, du, 32);
    v = signed_round_div(nv, dv, 32);
    if (v <= 0) return res;
    y = 64'd1 << 32;
    x = signed_round_div(3 * u, 2 * v, 32);
    z = signed_round_div((64'd4 << 32) - u - 10 * v, 2 * v, 32);
    r = 32404542 * x - 15371385 * y - 4985314 * z;
    g = -9692660 * x + 18760108 * y + 415560 * z;
    b = 556434 * x - 2040259 * y + 10572250 * z;
    m = r;
    if (g > m) m = g;
    if (b > m) m = b;
    if (m <= 0) return res;
    res.red = channel_ratio(r, m);
    res.green = channel_ratio(g, m);
    res.blue = channel_ratio(b, m);
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Hold valid across consecutive requests; drop it only for an idle burst
  task automatic send_request(logic [13:0] kelvin);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    temp_kelvin_i <= kelvin;
    do @(posedge clk_i); while (!in_ready_o);
    rgb_expected_q.push_back(kelvin_to_rgb(kelvin));
    @(negedge clk_i);
  endtask

  // Result side: random stalls, check on each accepted result
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (quiet_phase) out_ready_i <= 1'b1;
      else if ($urandom_range(0, 7) == 0) out_ready_i <= 1'b0;
      else if ($urandom_range(0, 2) == 0) out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rgb_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rgb_expected_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = rgb_expected_q.pop_front();
        if (red_o !== want.red) report_mismatch("red", red_o, want.red);
        if (green_o !== want.green) report_mismatch("green", green_o, want.green);
        if (blue_o !== want.blue) report_mismatch("blue", blue_o, want.blue);
      end
    end
  end

  task automatic test_directed();
    logic [13:0] points[$] = '{14'd0, 14'd1, 14'd999, 14'd1000, 14'd1001, 14'd1500,
      14'd2700, 14'd4000, 14'd5000, 14'd6500, 14'd6504, 14'd8000, 14'd10000,
      14'd14999, 14'd15000, 14'd15001, 14'h2AAA, 14'h1555, 14'h3FFF};
    foreach (points[i]) send_request(points[i]);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (rgb_expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_random_in_range(int count);
    for (int i = 0; i < count; i++) send_request(14'($urandom_range(1000, 15000)));
  endtask

  task automatic test_random_any(int count);
    for (int i = 0; i < count; i++) send_request(14'($urandom));
  endtask

  task automatic test_back_to_back(int count);
    quiet_phase = 1'b1;
    for (int i = 0; i < count; i++) send_request(14'($urandom_range(800, 16383)));
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    // hold until the pipeline is empty before going on
    drain_results();
    test_random_in_range(1000);
    test_random_any(450);
    test_back_to_back(300);
    drain_results();
    repeat (LATENCY + 20) @(negedge clk_i);
    if (error_count == 0 && rgb_expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
